// ===== rtl/core/msh_pkg.sv =====
`default_nettype none

package msh_pkg;

   // Motor lanes on the ports and the defaults for the top level parameters
   localparam int MOTOR_LANES        = 3;
   localparam int MOTOR_COUNT_DEF    = 3;
   localparam int POSITION_COUNT_DEF = 40;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int TGT_W      = 6;
   localparam int SAMPLE_W   = 12;
   localparam int POS_W      = 12;
   localparam int SPP_W      = 8;
   localparam int COIL_W     = 4;
   localparam int STATUS_W   = 3;
   localparam int HOME_CNT_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Smallest revolution used, and the shift steps that reduce a position
   // and a steps-per-position value modulo any revolution of at least REV_MIN
   localparam int REV_MIN     = 4;
   localparam int REV_MIN_LOG = 2;
   localparam int NORM_STEPS  = POS_W - REV_MIN_LOG;
   localparam int W0_STEPS    = SPP_W - REV_MIN_LOG;
   localparam int SHIFT_W     = $clog2(NORM_STEPS);
   localparam int DIV_W       = POS_W + NORM_STEPS - 1;

   localparam logic [POS_W-1:0]      REV_FLOOR   = POS_W'(REV_MIN);
   localparam logic [SAMPLE_W-1:0]   THR_RESET   = 12'd2048;
   localparam logic [POS_W-1:0]      REV_RESET   = 12'd2038;
   localparam logic [SPP_W-1:0]      SPP_RESET   = 8'd50;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HOME = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_BAD  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_HOME_DONE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_HOME_FAIL = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_MOVE_DONE = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_REJECT    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_POS  = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_HOME = 3'b010,
      MODE_MOVE = 3'b100
   } mode_type;

   typedef enum logic [3:0] {
      PREP_LOAD = 4'b0001,
      PREP_NORM = 4'b0010,
      PREP_FILL = 4'b0100,
      PREP_DONE = 4'b1000
   } prep_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [TGT_W-1:0]    target_a;
      logic [TGT_W-1:0]    target_b;
      logic [TGT_W-1:0]    target_c;
      logic [SAMPLE_W-1:0] endstop_a;
      logic [SAMPLE_W-1:0] endstop_b;
      logic [SAMPLE_W-1:0] endstop_c;
   } req_type;

   typedef struct packed {
      logic [COIL_W-1:0]      coils_a;
      logic [COIL_W-1:0]      coils_b;
      logic [COIL_W-1:0]      coils_c;
      logic                   busy_res;
      logic [MOTOR_LANES-1:0] homed_mask;
      logic [STATUS_W-1:0]    status;
   } rsp_type;

   // Sequencer to lanes: position reduction step and target table fill
   typedef struct packed {
      logic               norm_en;
      logic [SHIFT_W-1:0] norm_shift;
      logic               fill_we;
      logic [POS_W-1:0]   fill_data;
   } prep_ctl_type;

   // Top level to one lane, per item
   typedef struct packed {
      logic step;
      logic zero;
      logic load;
      logic coils_off;
   } lane_ctl_type;

   // Two adjacent wires on, starting at the current phase
   function automatic logic [COIL_W-1:0] coil_mask(input logic [1:0] phase);
      logic [COIL_W-1:0] mask;
      logic [1:0]        nxt;
      mask       = '0;
      nxt        = phase + 2'd1;
      mask[phase] = 1'b1;
      mask[nxt]   = 1'b1;
      return mask;
   endfunction

   // Revolution shifted left, for one restoring reduction step
   function automatic logic [DIV_W-1:0] div_shift(input logic [POS_W-1:0] rev,
                                                  input logic [SHIFT_W-1:0] shift);
      return DIV_W'(rev) << shift;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msh_prep.sv =====
`default_nettype none

module msh_prep #(
   parameter int POSITION_COUNT = msh_pkg::POSITION_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   restart,
   input  logic [msh_pkg::POS_W-1:0]              rev,
   input  logic [msh_pkg::SPP_W-1:0]              spp,
   output msh_pkg::prep_ctl_type                  prep_ctl,
   output logic [$clog2(POSITION_COUNT)-1:0]      fill_addr,
   output logic                                   busy
);
   import msh_pkg::*;

   localparam int IDX_W = $clog2(POSITION_COUNT);

   prep_state_type     state_ff, state_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [SPP_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]   acc_ff, acc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DIV_W-1:0]   divisor;
   logic [POS_W:0]     acc_sum;
   logic [POS_W:0]     acc_diff;

   assign divisor  = div_shift(rev, shift_ff);
   assign acc_sum  = {1'b0, acc_ff} + (POS_W+1)'(rem_ff);
   assign acc_diff = acc_sum - {1'b0, rev};

   always_comb begin
      state_in           = state_ff;
      shift_in           = shift_ff;
      rem_in             = rem_ff;
      acc_in             = acc_ff;
      idx_in             = idx_ff;
      prep_ctl           = '0;
      prep_ctl.norm_shift = shift_ff;
      prep_ctl.fill_data  = acc_ff;
      unique case (state_ff)
         PREP_LOAD: begin
            rem_in   = spp;
            shift_in = SHIFT_W'(NORM_STEPS - 1);
            state_in = PREP_NORM;
         end
         PREP_NORM: begin
            // lanes reduce positions; here spp is reduced to spp mod rev
            prep_ctl.norm_en = 1'b1;
            if (shift_ff < SHIFT_W'(W0_STEPS) && DIV_W'(rem_ff) >= divisor) begin
               rem_in = rem_ff - divisor[SPP_W-1:0];
            end
            if (shift_ff == '0) begin
               acc_in   = '0;
               idx_in   = '0;
               state_in = PREP_FILL;
            end else begin
               shift_in = shift_ff - SHIFT_W'(1);
            end
         end
         PREP_FILL: begin
            // entry t holds t * spp mod rev
            prep_ctl.fill_we = 1'b1;
            acc_in = acc_sum >= {1'b0, rev} ? acc_diff[POS_W-1:0] : acc_sum[POS_W-1:0];
            if (idx_ff == IDX_W'(POSITION_COUNT - 1)) begin
               state_in = PREP_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         PREP_DONE: begin
         end
         default: state_in = PREP_LOAD;
      endcase
      if (restart) begin
         state_in = PREP_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PREP_LOAD;
         shift_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         shift_ff <= shift_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign fill_addr = idx_ff;
   assign busy      = state_ff != PREP_DONE;

endmodule

`default_nettype wire

// ===== rtl/core/msh_lane.sv =====
`default_nettype none

module msh_lane #(
   parameter int POSITION_COUNT = msh_pkg::POSITION_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [msh_pkg::POS_W-1:0]           rev,
   input  msh_pkg::prep_ctl_type               prep_ctl,
   input  logic [$clog2(POSITION_COUNT)-1:0]   fill_addr,
   input  logic [$clog2(POSITION_COUNT)-1:0]   rd_addr,
   input  msh_pkg::lane_ctl_type               lane_ctl,
   output logic [msh_pkg::COIL_W-1:0]          coil_next,
   output logic                                at_target
);
   import msh_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]        phase_ff, phase_in;
   logic [COIL_W-1:0] coil_ff, coil_in;
   logic [POS_W-1:0]  tgt_ff;
   logic [POS_W-1:0]  tgt_mem [POSITION_COUNT];
   logic [DIV_W-1:0]  divisor;

   assign divisor = div_shift(rev, prep_ctl.norm_shift);

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      coil_in  = coil_ff;
      if (prep_ctl.norm_en && DIV_W'(pos_ff) >= divisor) begin
         pos_in = pos_ff - divisor[POS_W-1:0];
      end
      if (lane_ctl.zero) begin
         pos_in = '0;
      end else if (lane_ctl.step) begin
         coil_in  = coil_mask(phase_ff);
         phase_in = phase_ff + 2'd1;
         pos_in   = (pos_ff == rev - POS_W'(1)) ? '0 : pos_ff + POS_W'(1);
      end
      if (lane_ctl.coils_off) begin
         coil_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
         coil_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         coil_ff  <= coil_in;
      end
   end

   // target position table, one entry per display position
   always_ff @(posedge clock) begin
      if (prep_ctl.fill_we) begin
         tgt_mem[fill_addr] <= prep_ctl.fill_data;
      end
      if (lane_ctl.load) begin
         tgt_ff <= tgt_mem[rd_addr];
      end
   end

   assign coil_next = coil_in;
   assign at_target = pos_ff == tgt_ff;

endmodule

`default_nettype wire

// ===== rtl/core/multi_stepper_home_and_position.sv =====
`default_nettype none

// Channel   Direction  Handshake               Carries
// req_*     in         req_valid / req_stall   one tick, home or move command item
// rsp_*     out        rsp_valid / rsp_stall   coils, busy, homed mask, status
// csr_*     in         csr_valid / csr_ready   register index and write data
//
// Every item's result is registered at the edge that accepts it, so one item
// per cycle is taken while rsp_stall stays low and no setup pass runs.
// A two-entry output buffer (result register plus skid) keeps accepting while
// a result waits; req_stall rises only in a setup pass or when both are full.
// After reset and after every register write, a setup pass holds req_stall
// high and csr_ready low: it loads, then reduces positions modulo the
// revolution, then refills the per-motor target table.
// Reset is synchronous, active high.

module multi_stepper_home_and_position #(
   parameter int MOTOR_COUNT    = msh_pkg::MOTOR_COUNT_DEF,
   parameter int POSITION_COUNT = msh_pkg::POSITION_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  msh_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output msh_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msh_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import msh_pkg::*;

   localparam int NMOT  = (MOTOR_COUNT < MOTOR_LANES) ? MOTOR_COUNT : MOTOR_LANES;
   localparam int IDX_W = $clog2(POSITION_COUNT);
   localparam logic [TGT_W:0] POS_LIMIT = (TGT_W+1)'(POSITION_COUNT);

   // configuration registers
   logic [SAMPLE_W-1:0] thr_ff, thr_in;
   logic [POS_W-1:0]    spr_ff, spr_in;
   logic [SPP_W-1:0]    spp_ff, spp_in;
   logic [POS_W-1:0]    rev;
   logic [HOME_CNT_W-1:0] twice_rev;

   // operation state
   mode_type               mode_ff, mode_in;
   logic [MOTOR_LANES-1:0] homed_ff, homed_in;
   logic [HOME_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HOME_CNT_W-1:0]  cnt_next;

   // output buffer
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   rsp_type rsp_next;

   // setup pass and lanes
   prep_ctl_type      prep_ctl;
   logic [IDX_W-1:0]  fill_addr;
   logic              prep_busy;
   lane_ctl_type      lane_ctl  [MOTOR_LANES];
   logic [COIL_W-1:0] coil_next [MOTOR_LANES];
   logic              at_target [MOTOR_LANES];
   logic [TGT_W-1:0]  targets   [MOTOR_LANES];
   logic [SAMPLE_W-1:0] endstops [MOTOR_LANES];

   logic                req_accept;
   logic                csr_write;
   logic [STATUS_W-1:0] status;
   logic                all_home;
   logic                any_step;
   logic                tgt_bad;

   assign req_accept = req_valid & ~req_stall;
   assign csr_write  = csr_valid & csr_ready;
   assign csr_ready  = ~prep_busy;
   assign req_stall  = prep_busy | skid_valid_ff;

   assign targets[0]  = req_data.target_a;
   assign targets[1]  = req_data.target_b;
   assign targets[2]  = req_data.target_c;
   assign endstops[0] = req_data.endstop_a;
   assign endstops[1] = req_data.endstop_b;
   assign endstops[2] = req_data.endstop_c;

   // revolution never below four steps
   assign rev       = (spr_ff < REV_FLOOR) ? REV_FLOOR : spr_ff;
   assign twice_rev = {rev, 1'b0};

   //-------------------------------------------------------------------------
   // Register writes; each one restarts the setup pass
   //-------------------------------------------------------------------------
   always_comb begin
      thr_in = thr_ff;
      spr_in = spr_ff;
      spp_in = spp_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ZERO_THRESHOLD: thr_in = csr_wdata;
            CSR_STEPS_PER_REV:  spr_in = csr_wdata;
            CSR_STEPS_PER_POS:  spp_in = csr_wdata[SPP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         spr_ff <= REV_RESET;
         spp_ff <= SPP_RESET;
      end else begin
         thr_ff <= thr_in;
         spr_ff <= spr_in;
         spp_ff <= spp_in;
      end
   end

   msh_prep #(
      .POSITION_COUNT(POSITION_COUNT)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_write),
      .rev       (rev),
      .spp       (spp_ff),
      .prep_ctl  (prep_ctl),
      .fill_addr (fill_addr),
      .busy      (prep_busy)
   );

   //-------------------------------------------------------------------------
   // Motor lanes; missing motors read as coils off and already in place
   //-------------------------------------------------------------------------
   for (genvar m = 0; m < MOTOR_LANES; m++) begin : g_lane
      if (m < NMOT) begin : g_on
         msh_lane #(
            .POSITION_COUNT(POSITION_COUNT)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .rev       (rev),
            .prep_ctl  (prep_ctl),
            .fill_addr (fill_addr),
            .rd_addr   (targets[m][IDX_W-1:0]),
            .lane_ctl  (lane_ctl[m]),
            .coil_next (coil_next[m]),
            .at_target (at_target[m])
         );
      end else begin : g_off
         assign coil_next[m] = '0;
         assign at_target[m] = 1'b1;
      end
   end

   //-------------------------------------------------------------------------
   // Command decode and per-tick sequencing
   //-------------------------------------------------------------------------
   always_comb begin
      mode_in  = mode_ff;
      homed_in = homed_ff;
      cnt_in   = cnt_ff;
      cnt_next = cnt_ff + HOME_CNT_W'(1);
      status   = STAT_NONE;
      all_home = 1'b1;
      any_step = 1'b0;
      tgt_bad  = 1'b0;
      for (int m = 0; m < MOTOR_LANES; m++) begin
         lane_ctl[m] = '0;
         if ({1'b0, targets[m]} >= POS_LIMIT) begin
            tgt_bad = 1'b1;
         end
      end
      if (req_accept) begin
         if (req_data.cmd != CMD_TICK) begin
            // commands only arm; stepping happens on later ticks
            if (mode_ff != MODE_IDLE || req_data.cmd == CMD_BAD) begin
               status = STAT_REJECT;
            end else if (req_data.cmd == CMD_HOME) begin
               mode_in = MODE_HOME;
               cnt_in  = '0;
            end else if (tgt_bad) begin
               status = STAT_REJECT;
            end else begin
               // latch each motor's target step from its table
               for (int m = 0; m < MOTOR_LANES; m++) begin
                  lane_ctl[m].load = 1'b1;
               end
               mode_in = MODE_MOVE;
            end
         end else begin
            unique case (mode_ff)
               MODE_IDLE: begin
               end
               MODE_HOME: begin
                  for (int m = 0; m < MOTOR_LANES; m++) begin
                     if (m < NMOT) begin
                        if (endstops[m] > thr_ff) begin
                           lane_ctl[m].zero = 1'b1;
                           homed_in[m]      = 1'b1;
                        end else begin
                           lane_ctl[m].step = 1'b1;
                           all_home         = 1'b0;
                        end
                     end
                  end
                  if (all_home) begin
                     status  = STAT_HOME_DONE;
                     mode_in = MODE_IDLE;
                  end else begin
                     cnt_in = cnt_next;
                     if (cnt_next >= twice_rev) begin
                        status  = STAT_HOME_FAIL;
                        mode_in = MODE_IDLE;
                     end
                  end
               end
               MODE_MOVE: begin
                  // unhomed motors stay put
                  for (int m = 0; m < MOTOR_LANES; m++) begin
                     if (m < NMOT && homed_ff[m] && !at_target[m]) begin
                        lane_ctl[m].step = 1'b1;
                        any_step         = 1'b1;
                     end
                  end
                  if (!any_step) begin
                     for (int m = 0; m < MOTOR_LANES; m++) begin
                        lane_ctl[m].coils_off = 1'b1;
                     end
                     status  = STAT_MOVE_DONE;
                     mode_in = MODE_IDLE;
                  end
               end
               default: mode_in = MODE_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         homed_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         homed_ff <= homed_in;
         cnt_ff   <= cnt_in;
      end
   end

   //-------------------------------------------------------------------------
   // Result item and output buffer
   //-------------------------------------------------------------------------
   always_comb begin
      rsp_next.coils_a    = coil_next[0];
      rsp_next.coils_b    = coil_next[1];
      rsp_next.coils_c    = coil_next[2];
      rsp_next.busy_res   = mode_in != MODE_IDLE;
      rsp_next.homed_mask = homed_in;
      rsp_next.status     = status;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !rsp_stall) begin
         // result register is free this edge
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = rsp_next;
         end
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
